@@ design/rrpc_pkg.sv @@
// Shared types and constants for the rounded-rectangle pixel coverage block.
// No dependencies.
package rrpc_pkg;

  localparam int SurfaceDim = 4096;
  localparam int PixW       = 12;
  localparam int CoordW     = 16;
  localparam int RadW       = 14;
  localparam int ColorW     = 32;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTop    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRadius = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegColorA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegColorB = 3'd7;

  // Classified job handed from front to back.
  typedef struct packed {
    logic                     in_rect;  // pixel lies in the rectangle bounds
    logic signed [17:0]       rx;
    logic signed [17:0]       ry;
  } job_t;

endpackage

@@ design/rrpc_front.sv @@
// Front end: accepts pixel beats, computes offsets and bounds checks, pushes jobs
// into a two-entry queue. Depends on rrpc_pkg.
module rrpc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rrpc_pkg::PixW-1:0]          pixel_x_i,
  input  logic [rrpc_pkg::PixW-1:0]          pixel_y_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] left_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] top_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] width_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] height_i,
  output logic                               job_valid_o,
  input  logic                               job_pop_i,
  output rrpc_pkg::job_t                     job_o
);

  rrpc_pkg::job_t   q_mem [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  rrpc_pkg::job_t   job_new;
  logic             push;

  always_comb begin
    job_new.rx = 18'(signed'({1'b0, pixel_x_i})) - 18'(left_i);
    job_new.ry = 18'(signed'({1'b0, pixel_y_i})) - 18'(top_i);
    job_new.in_rect = (width_i > 0) && (height_i > 0) &&
                      (job_new.rx >= 0) && (job_new.rx < 18'(width_i)) &&
                      (job_new.ry >= 0) && (job_new.ry < 18'(height_i));
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= job_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (job_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

endmodule

@@ design/rrpc_back.sv @@
// Back end: per-job sequencer running up to two corner-inset binary searches on
// one shared squarer, then, in outline mode, the diagonal test; holds the result register.
// Depends on rrpc_pkg.
module rrpc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  output logic                               job_pop_o,
  input  rrpc_pkg::job_t                     job_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] width_i,
  input  logic signed [rrpc_pkg::CoordW-1:0] height_i,
  input  logic [rrpc_pkg::RadW-1:0]          radius_i,
  input  logic                               outline_i,
  input  logic [rrpc_pkg::ColorW-1:0]        color_a_i,
  input  logic [rrpc_pkg::ColorW-1:0]        color_b_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               paint_o,
  output logic [rrpc_pkg::ColorW-1:0]        pixel_color_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_SEARCH, S_DIAG1, S_DIAG2, S_DONE
  } state_e;

  state_e                 state_q;
  logic signed [17:0]     rx_q, ry_q;
  logic                   inside_q;
  logic [14:0]            rad_q;      // radius of current search
  logic [15:0]            h_q;        // height of current search
  logic signed [17:0]     row_q;
  logic [14:0]            lo_q, hi_q;
  logic signed [33:0]     dy2_q;      // dy*dy, registered
  logic                   pass_q;     // 0 outer, 1 inner
  logic [15:0]            outer_q;
  logic signed [35:0]     prod_a_q, prod_b_q;
  logic                   out_valid_q, paint_q;
  logic [rrpc_pkg::ColorW-1:0] color_q;
  logic                   paint_out_q;
  logic [rrpc_pkg::ColorW-1:0] color_out_q;

  logic [14:0]            rclamp;
  logic [14:0]            mid;
  logic signed [16:0]     dx;
  logic signed [33:0]     dxsq;
  logic signed [33:0]     rr;
  logic signed [17:0]     frow;
  logic signed [16:0]     dy;
  logic                   searchable;
  logic [15:0]            ins;
  logic                   has_inner;
  logic                   in_outer, in_inner, in_span;
  logic                   done_fire;

  // Radius clamp to half width and half height.
  always_comb begin
    logic [14:0] hw, hh, r;
    hw = width_i[15:1];
    hh = height_i[15:1];
    r  = {1'b0, radius_i};
    if (r > hw) r = hw;
    if (r > hh) r = hh;
    rclamp = r;
  end

  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  assign dx   = 17'(signed'({2'b0, rad_q}) * 2) - 17'(signed'({2'b0, mid}) * 2) - 17'sd1;
  assign dxsq = dx * dx;
  assign rr   = 34'(signed'({19'b0, rad_q})) * 34'(signed'({19'b0, rad_q})) * 4;

  // Folded row and search set-up for the current pass.
  always_comb begin
    frow = row_q;
    if (row_q >= 18'(signed'({2'b0, h_q[15:1]}))) frow = 18'(signed'({2'b0, h_q})) - 18'sd1 - row_q;
    searchable = (rad_q != 0) && (frow >= 0) && (frow < 18'(signed'({3'b0, rad_q})));
    dy = 17'(signed'({2'b0, rad_q}) * 2) - 17'(frow * 2) - 17'sd1;
  end

  assign ins       = {1'b0, lo_q};
  assign has_inner = ($signed(width_i) > 2) && (ry_q > 0) && (ry_q < 18'(height_i) - 18'sd1);
  assign in_outer  = (rx_q >= 18'(signed'({2'b0, outer_q}))) &&
                     (rx_q < 18'(width_i) - 18'(signed'({2'b0, outer_q})));
  // span of the search just finished, used by fill mode
  assign in_span   = (rx_q >= 18'(signed'({2'b0, ins}))) &&
                     (rx_q < 18'(width_i) - 18'(signed'({2'b0, ins})));
  assign in_inner  = (rx_q >= 18'(signed'({2'b0, ins})) + 18'sd1) &&
                     (rx_q < 18'(width_i) - 18'(signed'({2'b0, ins})) - 18'sd1);

  assign done_fire     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign job_pop_o     = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o   = out_valid_q;
  assign paint_o       = paint_out_q;
  assign pixel_color_o = color_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      paint_out_q <= 1'b0;
      color_out_q <= '0;
    end else begin
      // result register: loaded when the job finishes, held while stalled
      if (done_fire) begin
        out_valid_q <= 1'b1;
        paint_out_q <= paint_q;
        if (inside_q && outline_i && paint_q)
          color_out_q <= (prod_a_q < prod_b_q) ? color_a_i : color_b_i;
        else
          color_out_q <= color_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            rx_q     <= job_i.rx;
            ry_q     <= job_i.ry;
            inside_q <= job_i.in_rect;
            rad_q    <= rclamp;
            h_q      <= height_i;
            row_q    <= job_i.ry;
            pass_q   <= 1'b0;
            state_q  <= job_i.in_rect ? S_SETUP : S_DONE;
            paint_q  <= 1'b0;
            color_q  <= '0;
          end
        end
        S_SETUP: begin
          lo_q    <= '0;
          hi_q    <= searchable ? rad_q : 15'd0;
          dy2_q   <= dy * dy;
          state_q <= S_SEARCH;
        end
        S_SEARCH: begin
          if (lo_q < hi_q) begin
            if (dxsq + dy2_q <= rr) hi_q <= mid;
            else lo_q <= mid + 15'd1;
          end else if (!pass_q) begin
            outer_q <= ins;
            if (!outline_i) begin
              paint_q <= in_span;
              color_q <= in_span ? color_a_i : '0;
              state_q <= S_DONE;
            end else if (has_inner) begin
              pass_q  <= 1'b1;
              rad_q   <= (rad_q != 0) ? rad_q - 15'd1 : 15'd0;
              h_q     <= h_q - 16'd2;
              row_q   <= ry_q - 18'sd1;
              state_q <= S_SETUP;
            end else begin
              lo_q    <= '0;   // inner unused
              state_q <= S_DIAG1;
            end
          end else begin
            state_q <= S_DIAG1;
          end
        end
        S_DIAG1: begin
          prod_a_q <= 36'(rx_q) * 36'(height_i);
          prod_b_q <= 36'(ry_q) * 36'(width_i);
          paint_q  <= in_outer && !(pass_q && in_inner);
          state_q  <= S_DIAG2;
        end
        S_DIAG2: begin
          prod_a_q <= prod_a_q + prod_b_q;
          prod_b_q <= 36'(width_i) * 36'(height_i);
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/rounded_rect_pixel_coverage_top.sv @@
// Top level of the rounded-rectangle pixel coverage block: config registers,
// front classifier and back search engine. Depends on rrpc_pkg, rrpc_front, rrpc_back.
//
// One pixel beat in gives one result beat out, in order. The front computes the
// pixel's offsets and bounds in the accepting cycle and parks the job in a
// two-entry queue; the back runs each corner inset as a binary search, one
// compare step per cycle on one shared squarer. A pixel outside the rectangle
// goes from idle straight to done in the back. Inside, fill mode runs the set-up
// and one search step per bit of the clamped radius; outline mode runs the outer
// search, then the inner search on rows with an inner edge, then the diagonal
// test. The result register holds a finished beat while the back works on the
// next job and the front keeps taking new pixels.
// Configuration writes are always ready; write only while the block is idle.
module rounded_rect_pixel_coverage_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rrpc_pkg::PixW-1:0]         pixel_x_i,
  input  logic [rrpc_pkg::PixW-1:0]         pixel_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              paint_o,
  output logic [rrpc_pkg::ColorW-1:0]       pixel_color_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrpc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rrpc_pkg::ColorW-1:0]       cfg_data_i
);

  logic signed [rrpc_pkg::CoordW-1:0] left_q, top_q, width_q, height_q;
  logic [rrpc_pkg::RadW-1:0]          radius_q;
  logic                               outline_q;
  logic [rrpc_pkg::ColorW-1:0]        color_a_q, color_b_q;
  logic                               job_valid, job_pop;
  rrpc_pkg::job_t                     job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0; top_q <= '0; width_q <= '0; height_q <= '0;
      radius_q <= '0; outline_q <= 1'b0; color_a_q <= '0; color_b_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rrpc_pkg::RegLeft:   left_q    <= cfg_data_i[15:0];
        rrpc_pkg::RegTop:    top_q     <= cfg_data_i[15:0];
        rrpc_pkg::RegWidth:  width_q   <= cfg_data_i[15:0];
        rrpc_pkg::RegHeight: height_q  <= cfg_data_i[15:0];
        rrpc_pkg::RegRadius: radius_q  <= cfg_data_i[13:0];
        rrpc_pkg::RegMode:   outline_q <= cfg_data_i[0];
        rrpc_pkg::RegColorA: color_a_q <= cfg_data_i;
        rrpc_pkg::RegColorB: color_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rrpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .pixel_x_i, .pixel_y_i,
    .left_i(left_q), .top_i(top_q), .width_i(width_q), .height_i(height_q),
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  rrpc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .width_i(width_q), .height_i(height_q), .radius_i(radius_q),
    .outline_i(outline_q), .color_a_i(color_a_q), .color_b_i(color_b_q),
    .out_valid_o, .out_stall_i, .paint_o, .pixel_color_o
  );

endmodule

@@ design/rrpc_checker.sv @@
// Port-level checker for the rounded-rectangle pixel coverage block, bound to the top.
// Depends on rounded_rect_pixel_coverage_top ports only.
module rrpc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        paint_o,
  input logic [31:0] pixel_color_o,
  input logic        cfg_ready_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_color_o) && $stable(paint_o))
    else $error("stalled result changed");

  a_nopaint_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !paint_o |-> pixel_color_o == 32'd0)
    else $error("color without paint");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind rounded_rect_pixel_coverage_top rrpc_port_checker u_rrpc_port_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .paint_o, .pixel_color_o, .cfg_ready_o
);

@@ tb/rrpc_checker.sv @@
`timescale 1ns / 1ps
// Coverage checker: watches the pixel and result channels, predicts each result
// from the register shadow and compares in order. Depends on rrpc_pkg.
module rrpc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [rrpc_pkg::PixW-1:0]    pixel_x_i,
  input  logic [rrpc_pkg::PixW-1:0]    pixel_y_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         paint_i,
  input  logic [rrpc_pkg::ColorW-1:0]  pixel_color_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [rrpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rrpc_pkg::ColorW-1:0]  cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           painted_o
);

  typedef struct packed {
    logic        paint;
    logic [31:0] color;
  } coverage_t;

  coverage_t   pending_q[$];
  longint      left_r, top_r, width_r, height_r, radius_r;
  logic        outline_r;
  logic [31:0] color_a_r, color_b_r;

  function automatic longint clamp_rad(longint w, longint h, longint rad);
    if (rad > w / 2) rad = w / 2;
    if (rad > h / 2) rad = h / 2;
    return (rad > 0) ? rad : 0;
  endfunction

  // binary search for first column whose doubled center lies in the circle
  function automatic longint inset_for_row(longint h, longint rad, longint row);
    longint lo, hi, mid, dx, dy, rr;
    lo = 0;
    hi = rad;
    if (rad <= 0) return 0;
    if (row >= h / 2) row = h - 1 - row;
    if (row < 0 || row >= rad) return 0;
    dy = 2 * rad - 2 * row - 1;
    rr = 4 * rad * rad;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      dx  = 2 * rad - 2 * mid - 1;
      if (dx * dx + dy * dy <= rr) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic coverage_t cover_pixel(longint px, longint py);
    coverage_t res;
    longint    w, h, rx, ry, rad, outer, inn;
    logic      has_hole;
    res = '0;
    w = width_r;
    h = height_r;
    if (px >= rrpc_pkg::SurfaceDim || py >= rrpc_pkg::SurfaceDim || w <= 0 || h <= 0)
      return res;
    rx = px - left_r;
    ry = py - top_r;
    if (rx < 0 || rx >= w || ry < 0 || ry >= h) return res;
    rad   = clamp_rad(w, h, radius_r);
    outer = inset_for_row(h, rad, ry);
    if (!outline_r) begin
      if (rx >= outer && rx < w - outer) res = '{1'b1, color_a_r};
    end else begin
      has_hole = (w > 2) && (ry > 0) && (ry < h - 1);
      inn = has_hole ? 1 + inset_for_row(h - 2, (rad > 0) ? rad - 1 : 0, ry - 1) : 0;
      if (rx >= outer && rx < w - outer && !(has_hole && rx >= inn && rx < w - inn))
        res = '{1'b1, (rx * h + ry * w < w * h) ? color_a_r : color_b_r};
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    coverage_t want;
    if (!rst_ni) begin
      left_r <= 0; top_r <= 0; width_r <= 0; height_r <= 0; radius_r <= 0;
      outline_r <= 1'b0; color_a_r <= '0; color_b_r <= '0;
      fail_count_o <= 0;
      painted_o <= 0;
      pending_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rrpc_pkg::RegLeft:   left_r    <= longint'($signed(cfg_data_i[15:0]));
          rrpc_pkg::RegTop:    top_r     <= longint'($signed(cfg_data_i[15:0]));
          rrpc_pkg::RegWidth:  width_r   <= longint'($signed(cfg_data_i[15:0]));
          rrpc_pkg::RegHeight: height_r  <= longint'($signed(cfg_data_i[15:0]));
          rrpc_pkg::RegRadius: radius_r  <= longint'(cfg_data_i[13:0]);
          rrpc_pkg::RegMode:   outline_r <= cfg_data_i[0];
          rrpc_pkg::RegColorA: color_a_r <= cfg_data_i;
          rrpc_pkg::RegColorB: color_b_r <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        pending_q.push_back(cover_pixel(longint'(pixel_x_i), longint'(pixel_y_i)));
      if (out_valid_i && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_q.pop_front();
          if (paint_i) painted_o <= painted_o + 1;
          if (paint_i !== want.paint) begin
            $error("paint: expected %0b, got %0b", want.paint, paint_i);
            fail_count_o <= fail_count_o + 1;
          end else if (pixel_color_i !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, pixel_color_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = pending_q.size();
endmodule

@@ tb/rounded_rect_pixel_coverage_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, register programming and pixel stimulus for the
// rounded-rectangle coverage block. Depends on rrpc_pkg, rrpc_checker and the RTL.
module rounded_rect_pixel_coverage_top_tb;

  localparam int IdleLimit = 20000;  // cycles with no accepted beat

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [rrpc_pkg::PixW-1:0]     pixel_x_i = '0;
  logic [rrpc_pkg::PixW-1:0]     pixel_y_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          paint_o;
  logic [rrpc_pkg::ColorW-1:0]   pixel_color_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [rrpc_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [rrpc_pkg::ColorW-1:0]   cfg_data_i = '0;
  int                            fail_count, pending, painted;
  int                            pixels_sent;
  int                            idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  rounded_rect_pixel_coverage_top u_dut (.*);

  rrpc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .pixel_x_i, .pixel_y_i,
    .out_valid_i(out_valid_o), .out_stall_i, .paint_i(paint_o),
    .pixel_color_i(pixel_color_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .painted_o(painted)
  );

  // Watchdog: any accepted beat resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall stretches after accepted beats, some beats with none.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input logic [rrpc_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_rect(input int l, input int t, input int w, input int h,
                              input int rad, input logic mode);
    write_reg(rrpc_pkg::RegLeft, 32'(l));
    write_reg(rrpc_pkg::RegTop, 32'(t));
    write_reg(rrpc_pkg::RegWidth, 32'(w));
    write_reg(rrpc_pkg::RegHeight, 32'(h));
    write_reg(rrpc_pkg::RegRadius, 32'(rad));
    write_reg(rrpc_pkg::RegMode, {31'd0, mode});
    write_reg(rrpc_pkg::RegColorA, $urandom());
    write_reg(rrpc_pkg::RegColorB, $urandom());
  endtask

  // One pixel beat; a random gap drawn per paced beat, valid held across back-to-back.
  task automatic send_pixel(input int x, input int y, input bit pace);
    int gap;
    gap = pace ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= x[rrpc_pkg::PixW-1:0];
    pixel_y_i  <= y[rrpc_pkg::PixW-1:0];
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  // Idle point: stop sending, drain until no result is pending, then a quiet margin.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Pixel near the shape: mostly inside or along the border, some anywhere.
  task automatic random_pixel(input int l, input int t, input int w, input int h);
    int x, y;
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end else begin
      x = l + $urandom_range(0, (w > 0 ? w : 1) + 3) - 2;
      y = t + $urandom_range(0, (h > 0 ? h : 1) + 3) - 2;
    end
    send_pixel(x & 12'hfff, y & 12'hfff, 1'b1);
  endtask

  initial begin
    int l, t, w, h, rad;
    pixels_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state is an empty rect, then corners, edges, outline, extremes.
    send_pixel(0, 0, 1'b0);
    send_pixel(4095, 4095, 1'b0);
    drain();
    program_rect(10, 20, 40, 30, 8, 1'b0);
    send_pixel(10, 20, 1'b0);   // rounded-off corner
    send_pixel(14, 20, 1'b0);
    send_pixel(30, 35, 1'b0);   // middle
    send_pixel(49, 49, 1'b0);   // bottom-right corner
    send_pixel(50, 35, 1'b0);   // just right of the rect
    send_pixel(9, 35, 1'b0);
    drain();
    program_rect(100, 100, 20, 20, 16383, 1'b1);  // radius clamps, outline
    for (int i = 0; i < 20; i += 3) send_pixel(100 + i, 100 + i, 1'b0);
    send_pixel(101, 110, 1'b0);
    send_pixel(119, 110, 1'b0);
    drain();
    program_rect(-32768, -32768, 32767, 32767, 0, 1'b1);  // huge, square corners
    send_pixel(0, 0, 1'b0);
    send_pixel(4095, 4095, 1'b0);
    drain();
    program_rect(5, 5, 2, 6, 3, 1'b1);  // thin outline
    send_pixel(5, 7, 1'b0);
    send_pixel(6, 8, 1'b0);
    drain();
    program_rect(32767, 0, -32768, 10, 4, 1'b0);  // negative width
    send_pixel(0, 3, 1'b0);
    drain();

    // Random phases: mostly small shapes, a few large ones.
    while (pixels_sent < 620) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 4000);
        h = $urandom_range(1, 4000);
      end else begin
        w = $urandom_range(0, 40) - 2;
        h = $urandom_range(0, 40) - 2;
      end
      l   = $urandom_range(0, 4095) - (($urandom_range(0, 3) == 0) ? 1000 : 0);
      t   = $urandom_range(0, 4095) - (($urandom_range(0, 3) == 0) ? 1000 : 0);
      if ($urandom_range(0, 4) == 0) begin
        l = $urandom_range(0, 100);
        t = $urandom_range(0, 100);
      end
      rad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 25);
      program_rect(l, t, w, h, rad, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 3) == 0) random_pixel(l, t, w, h);
        else send_pixel((l + $urandom_range(0, 40)) & 12'hfff,
                        (t + $urandom_range(0, 40)) & 12'hfff, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    drain();
    $display("ran %0d pixel beats over fill and outline shapes, %0d painted",
             pixels_sent, painted);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
